>>> sv/kea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kea_pkg;

  // fixed field widths
  localparam int unsigned VIDX_W   = 10;
  localparam int unsigned VCOUNT_W = 11;
  localparam int unsigned OUTW_W   = 32;

  // parameter defaults
  localparam int unsigned VERTICES_DEF    = 1024;
  localparam int unsigned WEIGHT_BITS_DEF = 32;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 11'd1024;

  // control sequencer
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PARENT,
    S_GRAND,
    S_OUT
  } kea_state_e;

endpackage
`default_nettype wire

>>> sv/kea_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface kea_edge_if
  import kea_pkg::*;
#(
  parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [VIDX_W-1:0]      vertex_a;
  logic [VIDX_W-1:0]      vertex_b;
  logic [WEIGHT_BITS-1:0] edge_weight;

  modport source (output valid, vertex_a, vertex_b, edge_weight, input ready);
  modport sink   (input valid, vertex_a, vertex_b, edge_weight, output ready);
endinterface

interface kea_result_if
  import kea_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [VIDX_W-1:0] out_vertex_a;
  logic [VIDX_W-1:0] out_vertex_b;
  logic [OUTW_W-1:0] out_weight;
  logic              tree_complete;
  logic              order_error;

  modport source (output valid, accepted, out_vertex_a, out_vertex_b, out_weight,
                  tree_complete, order_error, input ready);
  modport sink   (input valid, accepted, out_vertex_a, out_vertex_b, out_weight,
                  tree_complete, order_error, output ready);
endinterface
`default_nettype wire

>>> sv/kruskal_edge_acceptor.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  payload                                            handshake
// edge_in   in   vertex_a, vertex_b, edge_weight                    valid/ready
// res_out   out  accepted, out_vertex_a/b, out_weight, flags        valid/ready
// cfg       in   vertex_count (cfg_wdata_i)                         cfg_we_i
//
// one edge at a time: after the transaction the roots of vertex_a and then vertex_b are
// found by path halving, each step costing a parent read and a grandparent read, and the
// result is loaded in S_OUT.
// after reset a clearing pass writes the identity into the parent table with
// edge_in.ready low; configuration writes are taken throughout.
// an edge is taken while the previous result still waits in the output register.
module kruskal_edge_acceptor
  import kea_pkg::*;
#(
  parameter int unsigned VERTICES    = VERTICES_DEF,
  parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [VCOUNT_W-1:0] cfg_wdata_i,
  kea_edge_if.sink                 edge_in,
  kea_result_if.source             res_out
);

  localparam int unsigned AW = $clog2(VERTICES);

  kea_state_e state_q, state_d;

  logic [AW-1:0]          clr_q, clr_d;
  logic [AW-1:0]          node_q, node_d;
  logic [AW-1:0]          ra_q, ra_d;
  logic                   phase_b_q, phase_b_d;
  logic                   acc_q, acc_d;
  logic [AW-1:0]          cnt_q, cnt_d;
  logic [WEIGHT_BITS-1:0] last_w_q, last_w_d;
  logic [VCOUNT_W-1:0]    vcount_q;
  logic                   out_valid_q, out_valid_d;

  logic [VIDX_W-1:0]      va_q, vb_q;
  logic [WEIGHT_BITS-1:0] w_q;
  logic                   oerr_q;

  logic                   ores_acc_q, ores_done_q, ores_oerr_q;
  logic [VIDX_W-1:0]      ores_va_q, ores_vb_q;
  logic [OUTW_W-1:0]      ores_w_q;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  logic                   in_fire, in_range, root_hit, out_free, load_out;
  logic [31:0]            target, cnt_ext;
  logic                   complete;

  kea_ram #(
    .WIDTH (AW),
    .DEPTH (VERTICES)
  ) u_parent (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign edge_in.ready = (state_q == S_IDLE);
  assign in_fire  = edge_in.valid && edge_in.ready;
  assign in_range = (32'(edge_in.vertex_a) < 32'(VERTICES)) &&
                    (32'(edge_in.vertex_b) < 32'(VERTICES));
  assign root_hit = (ram_rdata == node_q);
  assign out_free = !out_valid_q || res_out.ready;
  assign load_out = (state_q == S_OUT) && out_free;

  // completion target with clamping of vertex_count
  always_comb begin
    target = 32'(vcount_q);
    if (target < 32'd2) begin
      target = 32'd2;
    end
    if (target > 32'(VERTICES)) begin
      target = 32'(VERTICES);
    end
    cnt_ext  = 32'(cnt_q);
    complete = (cnt_ext >= target - 32'd1);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == AW'(VERTICES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_d = in_range ? S_PARENT : S_OUT;
        end
      end
      S_PARENT: begin
        if (!root_hit) begin
          state_d = S_GRAND;
        end else if (phase_b_q) begin
          state_d = S_OUT;
        end
      end
      S_GRAND: state_d = S_PARENT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // table access and datapath
  always_comb begin
    clr_d       = clr_q;
    node_d      = node_q;
    ra_d        = ra_q;
    phase_b_d   = phase_b_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    last_w_d    = last_w_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = node_q;
    ram_wdata   = ram_rdata;
    ram_raddr   = node_q;
    if (out_valid_q && res_out.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = clr_q;
        clr_d     = clr_q + AW'(1);
      end
      S_IDLE: begin
        if (in_fire) begin
          last_w_d  = edge_in.edge_weight;
          node_d    = AW'(edge_in.vertex_a);
          ram_raddr = AW'(edge_in.vertex_a);
          phase_b_d = 1'b0;
          acc_d     = 1'b0;
        end
      end
      S_PARENT: begin
        if (!root_hit) begin
          // step to the parent's parent
          ram_raddr = ram_rdata;
        end else if (!phase_b_q) begin
          ra_d      = node_q;
          node_d    = AW'(vb_q);
          ram_raddr = AW'(vb_q);
          phase_b_d = 1'b1;
        end else if (ra_q != node_q) begin
          // link first root under second
          ram_we    = 1'b1;
          ram_waddr = ra_q;
          ram_wdata = node_q;
          acc_d     = 1'b1;
          if (cnt_q < AW'(VERTICES - 1)) begin
            cnt_d = cnt_q + AW'(1);
          end
        end
      end
      S_GRAND: begin
        // path halving: node takes its grandparent
        ram_we    = 1'b1;
        ram_waddr = node_q;
        ram_wdata = ram_rdata;
        node_d    = ram_rdata;
        ram_raddr = ram_rdata;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      phase_b_q   <= 1'b0;
      acc_q       <= 1'b0;
      cnt_q       <= '0;
      last_w_q    <= '0;
      vcount_q    <= VCOUNT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      phase_b_q   <= phase_b_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      last_w_q    <= last_w_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    ra_q   <= ra_d;
    if (in_fire) begin
      va_q   <= edge_in.vertex_a;
      vb_q   <= edge_in.vertex_b;
      w_q    <= edge_in.edge_weight;
      oerr_q <= (edge_in.edge_weight < last_w_q);
    end
    if (load_out) begin
      ores_acc_q  <= acc_q;
      ores_va_q   <= va_q;
      ores_vb_q   <= vb_q;
      ores_w_q    <= OUTW_W'(w_q);
      ores_done_q <= complete;
      ores_oerr_q <= oerr_q;
    end
  end

  assign res_out.valid         = out_valid_q;
  assign res_out.accepted      = ores_acc_q;
  assign res_out.out_vertex_a  = ores_va_q;
  assign res_out.out_vertex_b  = ores_vb_q;
  assign res_out.out_weight    = ores_w_q;
  assign res_out.tree_complete = ores_done_q;
  assign res_out.order_error   = ores_oerr_q;

endmodule
`default_nettype wire

>>> sv/kea_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module kea_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> sv/kea_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module kea_checker
  import kea_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_accepted,
  input wire logic [VIDX_W-1:0] out_va,
  input wire logic [VIDX_W-1:0] out_vb,
  input wire logic [OUTW_W-1:0] out_w
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_va) && $stable(out_vb)
      && $stable(out_w) && $stable(out_accepted))
    else $error("stalled result changed");

  // one edge in flight: no transaction right after a transaction
  a_one_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transaction");

  // self-loop is never a tree edge
  a_self_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_va == out_vb) |-> !out_accepted)
    else $error("self-loop accepted");

  // a result needs an edge: no result appears the cycle after an input transaction
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result without processing time");

endmodule

bind kruskal_edge_acceptor kea_checker u_kea_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (edge_in.valid),
  .in_ready     (edge_in.ready),
  .out_valid    (res_out.valid),
  .out_ready    (res_out.ready),
  .out_accepted (res_out.accepted),
  .out_va       (res_out.out_vertex_a),
  .out_vb       (res_out.out_vertex_b),
  .out_w        (res_out.out_weight)
);
`default_nettype wire
